// ===== rtl/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types, constants and helpers of the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int WORD_W    = 32;
    localparam int PROD_W    = 64;
    localparam int DIV_STEPS = 32;     // one quotient bit per divider stage
    localparam int NUM_TERMS = 12;     // x, y, z times columns 0..3

    localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

    localparam logic FUNC_LOAD      = 1'b0;
    localparam logic FUNC_TRANSFORM = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic  sat;
        word_t val;
    } clamp_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic clamp_t clamp_prod(input prod_t v);
        clamp_t c;
        c.sat = 1'b0;
        c.val = v[WORD_W-1:0];
        if (v > prod_t'(S32_MAX))
        begin
            c.sat = 1'b1;
            c.val = S32_MAX;
        end
        else if (v < prod_t'(S32_MIN))
        begin
            c.sat = 1'b1;
            c.val = S32_MIN;
        end
        return c;
    endfunction

endpackage

// ===== rtl/hpt_in_if.sv =====
// ----------------------------------------------------------------------------
// hpt_in_if
// Input channel: matrix entry loads and points to transform.
// ----------------------------------------------------------------------------
interface hpt_in_if;
    logic                valid;
    logic                ready;
    logic                func;
    logic [3:0]          entry_index;
    logic signed [31:0]  entry_value;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  point_z;

    modport source (
        output valid, func, entry_index, entry_value, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, func, entry_index, entry_value, point_x, point_y, point_z,
        output ready
    );
endinterface

// ===== rtl/hpt_out_if.sv =====
// ----------------------------------------------------------------------------
// hpt_out_if
// Output channel: transformed points with status flags.
// ----------------------------------------------------------------------------
interface hpt_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  out_x;
    logic signed [31:0]  out_y;
    logic signed [31:0]  out_z;
    logic                w_zero;
    logic                saturated;

    modport source (
        output valid, out_x, out_y, out_z, w_zero, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, w_zero, saturated,
        output ready
    );
endinterface

// ===== rtl/hpt_div_lane.sv =====
// ----------------------------------------------------------------------------
// hpt_div_lane
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated, clamped.
// ----------------------------------------------------------------------------
module hpt_div_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  hpt_pkg::word_t        num,
    input  logic [31:0]           den,
    input  logic                  neg,
    output hpt_pkg::word_t        res,
    output logic                  sat
);
    localparam int STEPS = hpt_pkg::DIV_STEPS;

    logic [31:0] rem_reg [0:STEPS];
    logic [31:0] dlo_reg [0:STEPS];
    logic [31:0] q_reg   [0:STEPS];
    logic [31:0] den_reg [0:STEPS];
    logic        neg_reg [0:STEPS];
    logic        ovf_reg [0:STEPS];

    logic [31:0] nmag;
    logic [63:0] dvd;

    assign nmag = num[31] ? 32'(-num) : 32'(num);
    assign dvd  = 64'(nmag) << FRAC_BITS;

    // Top half of the dividend at or above den means the quotient needs 33+ bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= dvd[63:32];
            dlo_reg[0] <= dvd[31:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (dvd[63:32] >= den);
        end
    end

    genvar k;
    generate
        for (k = 1; k <= STEPS; k++)
        begin : g_step
            logic [32:0] t;
            logic        ge;
            logic [32:0] diff;

            assign t    = {rem_reg[k-1], dlo_reg[k-1][STEPS-k]};
            assign ge   = (t >= {1'b0, den_reg[k-1]});
            assign diff = t - {1'b0, den_reg[k-1]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[31:0] : t[31:0];
                    dlo_reg[k] <= dlo_reg[k-1];
                    q_reg[k]   <= {q_reg[k-1][30:0], ge};
                    den_reg[k] <= den_reg[k-1];
                    neg_reg[k] <= neg_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        res = hpt_pkg::word_t'(q_reg[STEPS]);
        sat = 1'b0;
        if (ovf_reg[STEPS])
        begin
            sat = 1'b1;
            res = neg_reg[STEPS] ? hpt_pkg::S32_MIN : hpt_pkg::S32_MAX;
        end
        else if (neg_reg[STEPS])
        begin
            if (q_reg[STEPS] > 32'h8000_0000)
            begin
                sat = 1'b1;
                res = hpt_pkg::S32_MIN;
            end
            else
            begin
                res = hpt_pkg::word_t'(-q_reg[STEPS]);
            end
        end
        else if (q_reg[STEPS][31])
        begin
            sat = 1'b1;
            res = hpt_pkg::S32_MAX;
        end
    end

endmodule

// ===== rtl/homogeneous_point_transform_core.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform_core
// 4x4 homogeneous transform of (x,y,z,1) with divide by w, signed fixed point.
// ----------------------------------------------------------------------------
//  channel  | dir | carries
//  ---------+-----+------------------------------------------------------
//  point    | in  | func, entry_index, entry_value, point_x/y/z
//  result   | out | out_x, out_y, out_z, w_zero, saturated
//
//  One word accepted per cycle. A load writes the matrix at acceptance and
//  gives no result. A transform passes through multiply, product clamp,
//  column sum, divider setup, 32 divider stages and the output register.
//  The whole pipeline and the input hold while the output word is not taken.
//  Reset clears the valid bits only; the matrix is undefined until loaded.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    hpt_in_if.sink           point,
    hpt_out_if.source        result
);
    localparam int STEPS = hpt_pkg::DIV_STEPS;
    localparam int NT    = hpt_pkg::NUM_TERMS;

    logic en;
    logic acc;

    hpt_pkg::word_t matrix_reg [0:15];

    hpt_pkg::prod_t prod_reg [0:NT-1];
    hpt_pkg::word_t cst1_reg [0:3];
    logic           v1_reg;

    hpt_pkg::word_t term_reg [0:NT-1];
    hpt_pkg::word_t cst2_reg [0:3];
    logic           sat2_reg;
    logic           v2_reg;

    hpt_pkg::word_t col_reg  [0:3];
    logic           sat3_reg;
    logic           v3_reg;

    logic           dv_reg   [0:STEPS];
    logic           dwz_reg  [0:STEPS];
    logic           dsat_reg [0:STEPS];
    hpt_pkg::word_t draw_reg [0:STEPS][0:2];

    hpt_pkg::word_t lane_res [0:2];
    logic           lane_sat [0:2];

    logic           out_valid_reg;
    hpt_pkg::word_t out_x_reg, out_y_reg, out_z_reg;
    logic           out_wz_reg, out_sat_reg;

    hpt_pkg::clamp_t term_c [0:NT-1];
    hpt_pkg::clamp_t col_c  [0:3];
    logic [NT-1:0]   term_sat;
    logic [3:0]      col_sat;
    logic [31:0]     wmag;

    assign en          = !out_valid_reg || result.ready;
    assign point.ready = en;
    assign acc         = point.valid && en;

    // Load words write the matrix directly.
    always_ff @(posedge clk)
    begin
        if (acc && point.func == hpt_pkg::FUNC_LOAD)
        begin
            matrix_reg[point.entry_index] <= point.entry_value;
        end
    end

    // Stage 1: products x*M[0][c], y*M[1][c], z*M[2][c].
    genvar c;
    generate
        for (c = 0; c < 4; c++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[c]     <= hpt_pkg::prod_t'(point.point_x) *
                                       hpt_pkg::prod_t'(matrix_reg[c]);
                    prod_reg[4 + c] <= hpt_pkg::prod_t'(point.point_y) *
                                       hpt_pkg::prod_t'(matrix_reg[4 + c]);
                    prod_reg[8 + c] <= hpt_pkg::prod_t'(point.point_z) *
                                       hpt_pkg::prod_t'(matrix_reg[8 + c]);
                    cst1_reg[c]     <= matrix_reg[12 + c];
                    cst2_reg[c]     <= cst1_reg[c];
                end
            end

            // Exact 64-bit sum of three clamped products and the constant row, then clamped.
            assign col_c[c] = hpt_pkg::clamp_prod(
                hpt_pkg::prod_t'(term_reg[c]) + hpt_pkg::prod_t'(term_reg[4 + c]) +
                hpt_pkg::prod_t'(term_reg[8 + c]) + hpt_pkg::prod_t'(cst2_reg[c]));
            assign col_sat[c] = col_c[c].sat;
        end
    endgenerate

    // Stage 2: floor shift by the fraction width, clamp.
    genvar t;
    generate
        for (t = 0; t < NT; t++)
        begin : g_term
            assign term_c[t]   = hpt_pkg::clamp_prod(prod_reg[t] >>> FRAC_BITS);
            assign term_sat[t] = term_c[t].sat;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    term_reg[t] <= term_c[t].val;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat2_reg <= |term_sat;
            for (int i = 0; i < 4; i++)
            begin
                col_reg[i] <= col_c[i].val;
            end
            sat3_reg <= sat2_reg | (|col_sat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= acc && point.func == hpt_pkg::FUNC_TRANSFORM;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign wmag = col_reg[3][31] ? 32'(-col_reg[3]) : 32'(col_reg[3]);

    genvar l;
    generate
        for (l = 0; l < 3; l++)
        begin : g_lane
            hpt_div_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .clk (clk),
                .en  (en),
                .num (col_reg[l]),
                .den (wmag),
                .neg (col_reg[l][31] ^ col_reg[3][31]),
                .res (lane_res[l]),
                .sat (lane_sat[l])
            );
        end
    endgenerate

    // Side line that keeps flags and undivided values aligned with the divider.
    genvar s;
    generate
        for (s = 0; s <= STEPS; s++)
        begin : g_dly
            if (s == 0)
            begin : g_head
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        dv_reg[0] <= 1'b0;
                    end
                    else if (en)
                    begin
                        dv_reg[0] <= v3_reg;
                    end
                end
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        dwz_reg[0]     <= (col_reg[3] == '0);
                        dsat_reg[0]    <= sat3_reg;
                        draw_reg[0][0] <= col_reg[0];
                        draw_reg[0][1] <= col_reg[1];
                        draw_reg[0][2] <= col_reg[2];
                    end
                end
            end
            else
            begin : g_body
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        dv_reg[s] <= 1'b0;
                    end
                    else if (en)
                    begin
                        dv_reg[s] <= dv_reg[s-1];
                    end
                end
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        dwz_reg[s]     <= dwz_reg[s-1];
                        dsat_reg[s]    <= dsat_reg[s-1];
                        draw_reg[s][0] <= draw_reg[s-1][0];
                        draw_reg[s][1] <= draw_reg[s-1][1];
                        draw_reg[s][2] <= draw_reg[s-1][2];
                    end
                end
            end
        end
    endgenerate

    // Output register: undivided values when w is zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_wz_reg <= dwz_reg[STEPS];
            if (dwz_reg[STEPS])
            begin
                out_x_reg   <= draw_reg[STEPS][0];
                out_y_reg   <= draw_reg[STEPS][1];
                out_z_reg   <= draw_reg[STEPS][2];
                out_sat_reg <= dsat_reg[STEPS];
            end
            else
            begin
                out_x_reg   <= lane_res[0];
                out_y_reg   <= lane_res[1];
                out_z_reg   <= lane_res[2];
                out_sat_reg <= dsat_reg[STEPS] | lane_sat[0] | lane_sat[1] | lane_sat[2];
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_x     = out_x_reg;
    assign result.out_y     = out_y_reg;
    assign result.out_z     = out_z_reg;
    assign result.w_zero    = out_wz_reg;
    assign result.saturated = out_sat_reg;

endmodule
